// ===== rtl/mh2_pkg.sv =====
// Shared constants and types for the MurmurHash2 string hash block.
// No dependencies; imported by the top level and its checker.
package mh2_pkg;

    localparam logic [31:0] MUR_M    = 32'h5bd1e995;
    localparam int unsigned MUR_R    = 24;
    localparam logic [31:0] MUR_SEED = 32'd5381;
    localparam int unsigned AVA_SH1  = 13;
    localparam int unsigned AVA_SH2  = 15;

    localparam int unsigned LEN_W  = 16;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned HASH_W = 32;

    // Item kind carried on tuser
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_BYTE  = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_WK1  = 6'b000010,
        ST_WK2  = 6'b000100,
        ST_WH   = 6'b001000,
        ST_TAIL = 6'b010000,
        ST_AVA  = 6'b100000
    } mh2_state_t;

endpackage

// ===== rtl/murmur2_string_hash.sv =====
// MurmurHash2 (32-bit, seed 5381) over a streamed byte string.
// Depends on mh2_pkg for constants and the sequencer state type.
//
// Usage:
//   Input channel s_*: each item is either a start item (s_tuser = 0) whose
//   s_tdata[15:0] gives the string length, or a byte item (s_tuser = 1) whose
//   s_tdata[23:16] carries the next string byte. Bytes are gathered
//   little-endian into 32-bit words.
//   Output channel m_*: one item per completed string, the 32-bit hash.
//   A start item with length zero yields the hash of the empty string.
//   Byte items with no string open are dropped; a start item while a string
//   is open discards it and begins anew.
// Sequencing:
//   A single constant multiplier (x 0x5bd1e995) is shared by all mixing
//   steps under a small sequencer, one multiply per cycle unless it holds
//   in the avalanche step. A start item goes on to the avalanche step when
//   the length is zero. A byte completing no word is only gathered; a byte
//   completing a word takes three multiplies. After the last byte come a
//   tail fold when 1 to 3 bytes are left over, then the avalanche. s_tready
//   is high only when idle.
// Reset and stall:
//   aresetn (synchronous, active low) clears the hash state and drops any
//   pending output. The result sits in an output register; input items are
//   still taken while it waits, and the sequencer holds in the avalanche
//   step only if a new result is ready before the old one is taken.
module murmur2_string_hash #(
    parameter logic [31:0] MAX_LENGTH = 32'd65535
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,   // [15:0] string_length, [23:16] data_byte
    input  logic                        s_tuser,   // [0] mode
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [mh2_pkg::HASH_W-1:0]  m_tdata    // [31:0] hash_value
);
    import mh2_pkg::*;

    mh2_state_t               state_reg, state_next;
    logic [HASH_W-1:0]        hash_reg, hash_next;
    logic [HASH_W-1:0]        k_reg, k_next;
    logic [23:0]              gather_reg, gather_next;
    logic [1:0]               biw_reg, biw_next;
    logic [LEN_W-1:0]         rem_reg, rem_next;
    logic                     open_reg, open_next;
    logic                     mvalid_reg, mvalid_next;
    logic [HASH_W-1:0]        mdata_reg, mdata_next;

    logic [LEN_W-1:0]         s_len;
    logic [BYTE_W-1:0]        s_byte;
    logic [LEN_W-1:0]         len_sat;
    logic                     s_acc;
    logic                     out_free;
    logic [HASH_W-1:0]        mul_in;
    logic [HASH_W-1:0]        mul_out;

    assign s_len  = s_tdata[15:0];
    assign s_byte = s_tdata[23:16];

    // Saturate lengths above the configured bound
    assign len_sat = ({16'd0, s_len} > MAX_LENGTH) ? MAX_LENGTH[LEN_W-1:0] : s_len;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !mvalid_reg || m_tready;

    // Shared multiplier: operand chosen by the sequencer step
    always_comb begin
        unique case (state_reg)
            ST_WK1:  mul_in = k_reg;
            ST_WK2:  mul_in = k_reg ^ (k_reg >> MUR_R);
            ST_WH:   mul_in = hash_reg;
            ST_TAIL: mul_in = hash_reg ^ {8'd0, gather_reg};
            ST_AVA:  mul_in = hash_reg ^ (hash_reg >> AVA_SH1);
            default: mul_in = hash_reg;
        endcase
    end

    assign mul_out = mul_in * MUR_M;

    always_comb begin
        state_next  = state_reg;
        hash_next   = hash_reg;
        k_next      = k_reg;
        gather_next = gather_reg;
        biw_next    = biw_reg;
        rem_next    = rem_reg;
        open_next   = open_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_tuser == MODE_START) begin
                        hash_next   = MUR_SEED ^ {16'd0, len_sat};
                        gather_next = '0;
                        biw_next    = '0;
                        rem_next    = len_sat;
                        if (len_sat == '0) begin
                            open_next  = 1'b0;
                            state_next = ST_AVA;
                        end else begin
                            open_next = 1'b1;
                        end
                    end else if (open_reg) begin
                        rem_next = rem_reg - 16'd1;
                        if (biw_reg == 2'd3) begin
                            // Word complete: mix it through the multiplier
                            k_next     = {s_byte, gather_reg};
                            state_next = ST_WK1;
                        end else begin
                            case (biw_reg)
                                2'd0:    gather_next[7:0]   = s_byte;
                                2'd1:    gather_next[15:8]  = s_byte;
                                default: gather_next[23:16] = s_byte;
                            endcase
                            biw_next = biw_reg + 2'd1;
                            if (rem_reg == 16'd1) begin
                                open_next  = 1'b0;
                                state_next = ST_TAIL;
                            end
                        end
                    end
                end
            end
            ST_WK1: begin
                k_next     = mul_out;
                state_next = ST_WK2;
            end
            ST_WK2: begin
                k_next     = mul_out;
                state_next = ST_WH;
            end
            ST_WH: begin
                hash_next   = mul_out ^ k_reg;
                gather_next = '0;
                biw_next    = '0;
                if (rem_reg == '0) begin
                    open_next  = 1'b0;
                    state_next = ST_AVA;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_TAIL: begin
                hash_next   = mul_out;
                gather_next = '0;
                biw_next    = '0;
                state_next  = ST_AVA;
            end
            ST_AVA: begin
                // Hold here until the output register is free
                if (out_free) begin
                    hash_next   = mul_out;
                    mdata_next  = mul_out ^ (mul_out >> AVA_SH2);
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            hash_reg   <= '0;
            gather_reg <= '0;
            biw_reg    <= '0;
            rem_reg    <= '0;
            open_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            hash_reg   <= hash_next;
            gather_reg <= gather_next;
            biw_reg    <= biw_next;
            rem_reg    <= rem_next;
            open_reg   <= open_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg     <= k_next;
        mdata_reg <= mdata_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule

// ===== rtl/mh2_checker.sv =====
// Port-level checks for murmur2_string_hash, attached with a bind.
// Depends on mh2_pkg for the item kind codes.
module mh2_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    import mh2_pkg::*;

    logic zero_start;
    assign zero_start = s_tvalid && s_tready && (s_tuser == MODE_START)
                        && (s_tdata[15:0] == 16'd0);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Drop any pending result at reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // An empty string sends the block into its avalanche step
    a_zero_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        zero_start |=> !s_tready)
        else $error("ready after empty start");

    // An empty string with a free output yields a result once the avalanche step has run
    a_zero_out: assert property (@(posedge aclk) disable iff (!aresetn)
        zero_start && !m_tvalid |-> ##2 m_tvalid)
        else $error("no result for empty start");

    // A new result only appears after a busy cycle
    a_rose_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without sequencer work");

endmodule

bind murmur2_string_hash mh2_checker u_mh2_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
